@@ rtl/core/r2fft_pkg.sv @@
// shared types, constants and helpers for the radix-2 fft with zero padding
// holds the twiddle rom contents, built at elaboration
// no dependencies
package r2fft_pkg;

   localparam int MAX_LOG2    = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int WORD_BITS   = 27;
   localparam int TW_BITS     = 18;
   localparam int NMAX        = 1 << MAX_LOG2;
   localparam int HALF_MAX    = NMAX >> 1;
   localparam int HALF_BITS   = MAX_LOG2 - 1;
   localparam int LG_BITS     = 4;
   localparam int CNT_BITS    = MAX_LOG2 + 1;

   // request codes
   localparam logic [1:0] REQ_LOAD      = 2'd0;
   localparam logic [1:0] REQ_TRANSFORM = 2'd1;
   localparam logic [1:0] REQ_READ      = 2'd2;

   // status codes
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_DROPPED = 2'd1;
   localparam logic [1:0] STAT_NO_XFRM = 2'd2;

   typedef logic [2*TW_BITS-1:0] tw_rom_type [HALF_MAX];

   // round to nearest in q1.16
   function automatic logic [TW_BITS-1:0] q16_round(input real v);
      real    scaled;
      integer ival;
      begin
         scaled = $floor(v * 65536.0 + 0.5);
         ival   = $rtoi(scaled);
         q16_round = TW_BITS'(ival);
      end
   endfunction

   // cos and -sin of 2*pi*i/NMAX, real part in the upper half
   function automatic tw_rom_type build_tw_rom();
      tw_rom_type rom;
      real        pi_val;
      real        x;
      integer     j;
      logic [TW_BITS-1:0] c_q;
      logic [TW_BITS-1:0] s_q;
      begin
         pi_val = 3.14159265358979323846;
         for (int i = 0; i < HALF_MAX; i++) begin
            j = (4 * i > NMAX) ? i - NMAX / 4 : i;
            x = 2.0 * pi_val * j / NMAX;
            c_q = q16_round($cos(x));
            s_q = q16_round($sin(x));
            if (4 * i > NMAX) begin
               rom[i] = {TW_BITS'(-s_q), TW_BITS'(-c_q)};
            end else begin
               rom[i] = {c_q, TW_BITS'(-s_q)};
            end
         end
         build_tw_rom = rom;
      end
   endfunction

   localparam tw_rom_type TW_ROM = build_tw_rom();

   // reverse the low lg bits of an address
   function automatic logic [MAX_LOG2-1:0] bit_rev(input logic [MAX_LOG2-1:0] p,
                                                   input logic [LG_BITS-1:0] lg);
      logic [MAX_LOG2-1:0] r;
      begin
         for (int b = 0; b < MAX_LOG2; b++) begin
            r[MAX_LOG2-1-b] = p[b];
         end
         bit_rev = r >> (LG_BITS'(MAX_LOG2) - lg);
      end
   endfunction

endpackage

@@ rtl/core/radix2_fft_zero_pad.sv @@
// frame loader and in-place radix-2 decimation-in-time fft, top level; depends on r2fft_pkg
// load, unknown or early read: busy stays low, result the cycle after acceptance
// read bin: busy in ST_RD_BIN after the registered buffer read, result registered from ST_RD_BIN
// transform busy: zero pad of the N - loaded missing samples, bit-reverse swaps, then butterflies
//   (N/2*log2N on the one memory port), result registered in ST_DONE; results never stall
// reset clears control, count and valid flag; buffer contents stay undefined
module radix2_fft_zero_pad
   import r2fft_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  logic [MAX_LOG2-1:0]           req_bin_index,
   output logic                          rsp_valid,
   output logic signed [WORD_BITS-1:0]   rsp_bin_real,
   output logic signed [WORD_BITS-1:0]   rsp_bin_imag,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [LG_BITS-1:0]            csr_log2_len
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_BIN, ST_PAD, ST_BR_RD_P, ST_BR_RD_R, ST_BR_WR_P, ST_BR_WR_R,
      ST_BF_RD_B, ST_BF_RD_A, ST_BF_MUL, ST_BF_RND, ST_BF_WR_A, ST_BF_WR_B, ST_DONE
   } state_type;

   localparam int PROD_BITS = WORD_BITS + TW_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int T_BITS    = SUM_BITS - 16;
   localparam int ACC_BITS  = T_BITS + 1;

   state_type                  state_ff;
   logic [LG_BITS-1:0]         log2_len_ff;
   logic [LG_BITS-1:0]         lg_ff;
   logic [LG_BITS-1:0]         frame_lg_ff;
   logic [CNT_BITS-1:0]        count_ff;
   logic                       result_valid_ff;
   logic [CNT_BITS-1:0]        p_ff;
   logic [LG_BITS-1:0]         s_ff;
   logic [HALF_BITS-1:0]       j_ff;
   logic [2*WORD_BITS-1:0]     tmp_ff;
   logic signed [WORD_BITS-1:0] br_ff, bi_ff, ar_ff, ai_ff;
   logic signed [TW_BITS-1:0]  twr_ff, twi_ff;
   logic signed [PROD_BITS-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [T_BITS-1:0]   tr_ff, ti_ff;
   logic [2*TW_BITS-1:0]       tw_q_ff;

   // buffer memory, real part in the upper half
   logic [2*WORD_BITS-1:0]     mem [NMAX];
   logic [2*WORD_BITS-1:0]     rdata_ff;
   logic                       mem_we;
   logic [MAX_LOG2-1:0]        mem_waddr;
   logic [2*WORD_BITS-1:0]     mem_wdata;
   logic [MAX_LOG2-1:0]        mem_raddr;

   logic                       accept;
   logic [LG_BITS-1:0]         eff_lg;
   logic [CNT_BITS-1:0]        n_eff;
   logic [CNT_BITS-1:0]        n_cur;
   logic [MAX_LOG2-1:0]        p_addr;
   logic [MAX_LOG2-1:0]        rev_addr;
   logic [MAX_LOG2-1:0]        frame_mask;
   logic [MAX_LOG2-1:0]        half_mask;
   logic [MAX_LOG2-1:0]        j_ext;
   logic [MAX_LOG2-1:0]        ia_addr;
   logic [MAX_LOG2-1:0]        ib_addr;
   logic [HALF_BITS-1:0]       tw_addr;
   logic [HALF_BITS-1:0]       j_last;
   logic signed [SUM_BITS-1:0] sum_re, sum_im;
   logic signed [ACC_BITS-1:0] a_plus_r, a_plus_i, a_minus_r, a_minus_i;
   logic signed [SAMPLE_BITS-1:0] sample_s;

   function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] hi;
      logic signed [ACC_BITS-1:0] lo;
      begin
         hi = ACC_BITS'((1 <<< (WORD_BITS - 1)) - 1);
         lo = -ACC_BITS'(1 <<< (WORD_BITS - 1));
         if (v > hi) sat_word = hi[WORD_BITS-1:0];
         else if (v < lo) sat_word = lo[WORD_BITS-1:0];
         else sat_word = v[WORD_BITS-1:0];
      end
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign sample_s  = req_sample_value;

   // effective length and addressing
   always_comb begin
      if (log2_len_ff == '0) eff_lg = LG_BITS'(1);
      else if (log2_len_ff > LG_BITS'(MAX_LOG2)) eff_lg = LG_BITS'(MAX_LOG2);
      else eff_lg = log2_len_ff;
      n_eff      = CNT_BITS'(1) << eff_lg;
      n_cur      = CNT_BITS'(1) << lg_ff;
      p_addr     = p_ff[MAX_LOG2-1:0];
      rev_addr   = bit_rev(p_addr, lg_ff);
      frame_mask = (MAX_LOG2'(1) << frame_lg_ff) - MAX_LOG2'(1);
      half_mask  = (MAX_LOG2'(1) << s_ff) - MAX_LOG2'(1);
      j_ext      = {1'b0, j_ff};
      ia_addr    = ((j_ext & ~half_mask) << 1) | (j_ext & half_mask);
      ib_addr    = ia_addr | (MAX_LOG2'(1) << s_ff);
      tw_addr    = HALF_BITS'((j_ext & half_mask) << (LG_BITS'(HALF_BITS) - s_ff));
      j_last     = HALF_BITS'((n_cur >> 1) - CNT_BITS'(1));
   end

   // butterfly arithmetic
   always_comb begin
      sum_re    = SUM_BITS'(p_rr_ff) - SUM_BITS'(p_ii_ff) + SUM_BITS'(32768);
      sum_im    = SUM_BITS'(p_ri_ff) + SUM_BITS'(p_ir_ff) + SUM_BITS'(32768);
      a_plus_r  = ACC_BITS'(ar_ff) + ACC_BITS'(tr_ff);
      a_plus_i  = ACC_BITS'(ai_ff) + ACC_BITS'(ti_ff);
      a_minus_r = ACC_BITS'(ar_ff) - ACC_BITS'(tr_ff);
      a_minus_i = ACC_BITS'(ai_ff) - ACC_BITS'(ti_ff);
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = p_addr;
      mem_wdata = '0;
      mem_raddr = p_addr;
      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = req_bin_index & frame_mask;
            mem_waddr = count_ff[MAX_LOG2-1:0];
            mem_wdata = {WORD_BITS'(sample_s), {WORD_BITS{1'b0}}};
            mem_we    = accept && (req_type == REQ_LOAD) && (count_ff < n_eff);
         end
         ST_PAD: mem_we = 1'b1;
         ST_BR_RD_R: mem_raddr = rev_addr;
         ST_BR_WR_P: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
         end
         ST_BR_WR_R: begin
            mem_we    = 1'b1;
            mem_waddr = rev_addr;
            mem_wdata = tmp_ff;
         end
         ST_BF_RD_B: mem_raddr = ib_addr;
         ST_BF_RD_A: mem_raddr = ia_addr;
         ST_BF_WR_A: begin
            mem_we    = 1'b1;
            mem_waddr = ia_addr;
            mem_wdata = {sat_word(a_plus_r), sat_word(a_plus_i)};
         end
         ST_BF_WR_B: begin
            mem_we    = 1'b1;
            mem_waddr = ib_addr;
            mem_wdata = {sat_word(a_minus_r), sat_word(a_minus_i)};
         end
         default: mem_we = 1'b0;
      endcase
   end

   // buffer memory and twiddle rom, registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
      tw_q_ff  <= TW_ROM[tw_addr];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_BR_RD_R: tmp_ff <= rdata_ff;
         ST_BF_RD_A: begin
            br_ff  <= rdata_ff[2*WORD_BITS-1:WORD_BITS];
            bi_ff  <= rdata_ff[WORD_BITS-1:0];
            twr_ff <= tw_q_ff[2*TW_BITS-1:TW_BITS];
            twi_ff <= tw_q_ff[TW_BITS-1:0];
         end
         ST_BF_MUL: begin
            ar_ff   <= rdata_ff[2*WORD_BITS-1:WORD_BITS];
            ai_ff   <= rdata_ff[WORD_BITS-1:0];
            p_rr_ff <= PROD_BITS'(twr_ff) * PROD_BITS'(br_ff);
            p_ii_ff <= PROD_BITS'(twi_ff) * PROD_BITS'(bi_ff);
            p_ri_ff <= PROD_BITS'(twr_ff) * PROD_BITS'(bi_ff);
            p_ir_ff <= PROD_BITS'(twi_ff) * PROD_BITS'(br_ff);
         end
         ST_BF_RND: begin
            tr_ff <= T_BITS'(sum_re >>> 16);
            ti_ff <= T_BITS'(sum_im >>> 16);
         end
         default: tmp_ff <= tmp_ff;
      endcase
   end

   // sequencer with registered result outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         log2_len_ff     <= LG_BITS'(9);
         lg_ff           <= LG_BITS'(1);
         frame_lg_ff     <= LG_BITS'(1);
         count_ff        <= '0;
         result_valid_ff <= 1'b0;
         p_ff            <= '0;
         s_ff            <= '0;
         j_ff            <= '0;
         rsp_valid       <= 1'b0;
         rsp_bin_real    <= '0;
         rsp_bin_imag    <= '0;
         rsp_status      <= STAT_DONE;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_valid && csr_ready) begin
            log2_len_ff <= csr_log2_len;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_bin_real <= '0;
                  rsp_bin_imag <= '0;
                  rsp_status   <= STAT_DONE;
                  case (req_type)
                     REQ_LOAD: begin
                        rsp_valid <= 1'b1;
                        if (count_ff >= n_eff) begin
                           rsp_status <= STAT_DROPPED;
                        end else begin
                           count_ff        <= count_ff + CNT_BITS'(1);
                           result_valid_ff <= 1'b0;
                        end
                     end
                     REQ_TRANSFORM: begin
                        lg_ff <= eff_lg;
                        s_ff  <= '0;
                        j_ff  <= '0;
                        if (count_ff < n_eff) begin
                           p_ff     <= count_ff;
                           state_ff <= ST_PAD;
                        end else begin
                           p_ff     <= '0;
                           state_ff <= ST_BR_RD_P;
                        end
                     end
                     REQ_READ: begin
                        if (!result_valid_ff) begin
                           rsp_valid  <= 1'b1;
                           rsp_status <= STAT_NO_XFRM;
                        end else begin
                           state_ff <= ST_RD_BIN;
                        end
                     end
                     default: rsp_valid <= 1'b1;
                  endcase
               end
            end
            ST_RD_BIN: begin
               rsp_valid    <= 1'b1;
               rsp_bin_real <= rdata_ff[2*WORD_BITS-1:WORD_BITS];
               rsp_bin_imag <= rdata_ff[WORD_BITS-1:0];
               state_ff     <= ST_IDLE;
            end
            // zero the tail of the frame
            ST_PAD: begin
               if (p_ff == n_cur - CNT_BITS'(1)) begin
                  p_ff     <= '0;
                  state_ff <= ST_BR_RD_P;
               end else begin
                  p_ff <= p_ff + CNT_BITS'(1);
               end
            end
            // bit-reverse reorder, swap only when the partner is higher
            ST_BR_RD_P: begin
               if (rev_addr > p_addr) begin
                  state_ff <= ST_BR_RD_R;
               end else if (p_ff == n_cur - CNT_BITS'(1)) begin
                  state_ff <= ST_BF_RD_B;
               end else begin
                  p_ff <= p_ff + CNT_BITS'(1);
               end
            end
            ST_BR_RD_R: state_ff <= ST_BR_WR_P;
            ST_BR_WR_P: state_ff <= ST_BR_WR_R;
            ST_BR_WR_R: begin
               p_ff     <= p_ff + CNT_BITS'(1);
               state_ff <= ST_BR_RD_P;
            end
            // butterfly read, multiply, round, write back
            ST_BF_RD_B: state_ff <= ST_BF_RD_A;
            ST_BF_RD_A: state_ff <= ST_BF_MUL;
            ST_BF_MUL:  state_ff <= ST_BF_RND;
            ST_BF_RND:  state_ff <= ST_BF_WR_A;
            ST_BF_WR_A: state_ff <= ST_BF_WR_B;
            ST_BF_WR_B: begin
               if (j_ff == j_last) begin
                  j_ff <= '0;
                  if (s_ff == lg_ff - LG_BITS'(1)) begin
                     state_ff <= ST_DONE;
                  end else begin
                     s_ff     <= s_ff + LG_BITS'(1);
                     state_ff <= ST_BF_RD_B;
                  end
               end else begin
                  j_ff     <= j_ff + HALF_BITS'(1);
                  state_ff <= ST_BF_RD_B;
               end
            end
            ST_DONE: begin
               frame_lg_ff     <= lg_ff;
               count_ff        <= '0;
               result_valid_ff <= 1'b1;
               rsp_valid       <= 1'b1;
               state_ff        <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for radix2_fft_zero_pad: loads, transforms and bin reads
// checked against an in-bench fixed-point fft predictor; depends on r2fft_pkg and the rtl
module testbench;
   import r2fft_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_type = REQ_LOAD;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic [MAX_LOG2-1:0]           req_bin_index = '0;
   logic                          rsp_valid;
   logic signed [WORD_BITS-1:0]   rsp_bin_real;
   logic signed [WORD_BITS-1:0]   rsp_bin_imag;
   logic [1:0]                    rsp_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [LG_BITS-1:0]            csr_log2_len = '0;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam longint     WORD_MIN    = -(64'sd1 <<< 26);
   localparam longint     WORD_MAX    = (64'sd1 <<< 26) - 1;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] re;
      logic signed [WORD_BITS-1:0] im;
      logic [1:0]                  status;
   } bin_result_type;

   // predictor state
   longint          cos_q16 [HALF_MAX];
   longint          nsin_q16 [HALF_MAX];
   longint          frame_re [NMAX];
   longint          frame_im [NMAX];
   int unsigned     sample_count;
   bit              bins_valid;
   int unsigned     last_frame_lg;
   logic [3:0]      len_reg;

   bin_result_type  pending_bins [$];
   int              mismatch_count = 0;
   bit              quiet = 1'b0;
   int              items_sent = 0;

   radix2_fft_zero_pad DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_sample_value(req_sample_value),
      .req_bin_index(req_bin_index), .rsp_valid(rsp_valid),
      .rsp_bin_real(rsp_bin_real), .rsp_bin_imag(rsp_bin_imag),
      .rsp_status(rsp_status), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_log2_len(csr_log2_len)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // 64x64 product shifted right, modulo 2^64
   function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                 int s);
      logic [127:0] p;
      begin
         p = {64'd0, a} * {64'd0, b};
         mul_shift = 64'(p >> s);
      end
   endfunction

   function automatic longint q62_round(longint unsigned v);
      begin
         if (v[63]) q62_round = 0;
         else q62_round = longint'((v + (64'd1 << 45)) >> 46);
      end
   endfunction

   // exact twiddle table: taylor series in q62
   task automatic build_twiddles();
      longint unsigned x, term, c, s;
      int              j;
      bit              upper;
      begin
         for (int i = 0; i < HALF_MAX; i++) begin
            upper = (4 * i > NMAX);
            j = upper ? i - NMAX / 4 : i;
            x = mul_shift(64'hC90FDAA22168C235, 64'(2 * j), MAX_LOG2);
            term = 64'd1 << 62;
            c = term;
            s = 0;
            for (int n = 1; n <= 32; n++) begin
               term = mul_shift(term, x, 62) / 64'(n);
               case (n % 4)
                  1: s += term;
                  2: c -= term;
                  3: s -= term;
                  default: c += term;
               endcase
            end
            if (upper) begin
               cos_q16[i]  = -q62_round(s);
               nsin_q16[i] = -q62_round(c);
            end else begin
               cos_q16[i]  = q62_round(c);
               nsin_q16[i] = -q62_round(s);
            end
         end
      end
   endtask

   function automatic longint clip_word(longint v);
      begin
         clip_word = (v < WORD_MIN) ? WORD_MIN : (v > WORD_MAX) ? WORD_MAX : v;
      end
   endfunction

   function automatic int unsigned active_lg();
      begin
         active_lg = (len_reg < 1) ? 1 : (len_reg > MAX_LOG2) ? MAX_LOG2 : len_reg;
      end
   endfunction

   // zero pad, bit-reverse, butterflies
   task automatic run_fft(int unsigned lg);
      int unsigned n, r, half, w, ia, ib;
      longint      t, br, bi, tr, ti, ar, ai;
      begin
         n = 1 << lg;
         for (int unsigned p = (sample_count < n ? sample_count : n); p < n; p++)
            frame_re[p] = 0;
         for (int unsigned p = 0; p < n; p++) frame_im[p] = 0;
         for (int unsigned p = 0; p < n; p++) begin
            r = 0;
            for (int unsigned b = 0; b < lg; b++)
               if (p[b]) r |= 1 << (lg - 1 - b);
            if (r > p) begin
               t = frame_re[p]; frame_re[p] = frame_re[r]; frame_re[r] = t;
               t = frame_im[p]; frame_im[p] = frame_im[r]; frame_im[r] = t;
            end
         end
         for (int unsigned s = 0; s < lg; s++) begin
            half = 1 << s;
            for (int unsigned g = 0; g < n; g += 2 * half) begin
               for (int unsigned k = 0; k < half; k++) begin
                  w  = (k << (MAX_LOG2 - s - 1)) & (HALF_MAX - 1);
                  ia = g + k;
                  ib = ia + half;
                  br = frame_re[ib];
                  bi = frame_im[ib];
                  tr = (cos_q16[w] * br - nsin_q16[w] * bi + 32768) >>> 16;
                  ti = (cos_q16[w] * bi + nsin_q16[w] * br + 32768) >>> 16;
                  ar = frame_re[ia];
                  ai = frame_im[ia];
                  frame_re[ia] = clip_word(ar + tr);
                  frame_im[ia] = clip_word(ai + ti);
                  frame_re[ib] = clip_word(ar - tr);
                  frame_im[ib] = clip_word(ai - ti);
               end
            end
         end
      end
   endtask

   // expected result of one request, updates predictor state
   task automatic predict_bin(logic [1:0] kind, logic signed [15:0] smp,
                              logic [9:0] idx, output bin_result_type res);
      int unsigned k;
      begin
         res = '0;
         case (kind)
            REQ_LOAD: begin
               if (sample_count >= (1 << active_lg())) begin
                  res.status = STAT_DROPPED;
               end else begin
                  frame_re[sample_count] = longint'(smp);
                  frame_im[sample_count] = 0;
                  sample_count++;
                  bins_valid = 1'b0;
               end
            end
            REQ_TRANSFORM: begin
               run_fft(active_lg());
               last_frame_lg = active_lg();
               sample_count = 0;
               bins_valid = 1'b1;
            end
            REQ_READ: begin
               if (!bins_valid) begin
                  res.status = STAT_NO_XFRM;
               end else begin
                  k = idx & ((1 << last_frame_lg) - 1);
                  res.re = WORD_BITS'(frame_re[k]);
                  res.im = WORD_BITS'(frame_im[k]);
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      begin
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         mismatch_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_bins.size() == 0) begin
            report_mismatch("unexpected transaction, status", rsp_status, -1);
         end else begin
            want = pending_bins.pop_front();
            if (rsp_bin_real !== want.re) report_mismatch("bin_real", rsp_bin_real, want.re);
            if (rsp_bin_imag !== want.im) report_mismatch("bin_imag", rsp_bin_imag, want.im);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // send one request; called and returns at a falling edge
   task automatic send_req(logic [1:0] kind, logic signed [15:0] smp, logic [9:0] idx);
      bin_result_type res;
      begin
         if (!quiet && $urandom_range(3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         start = 1'b1;
         req_type = kind;
         req_sample_value = smp;
         req_bin_index = idx;
         forever begin
            @(posedge clock);
            if (!busy) break;
         end
         predict_bin(kind, smp, idx, res);
         pending_bins.push_back(res);
         items_sent++;
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      begin
         start = 1'b0;
         while (pending_bins.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
      end
   endtask

   task automatic write_len(logic [3:0] lg);
      begin
         wait_drained();
         csr_valid = 1'b1;
         csr_log2_len = lg;
         forever begin
            @(posedge clock);
            if (csr_ready) break;
         end
         len_reg = lg;
         @(negedge clock);
         csr_valid = 1'b0;
      end
   endtask

   task automatic load_rand();
      begin
         send_req(REQ_LOAD, 16'($urandom), '0);
      end
   endtask

   task automatic read_rand();
      begin
         send_req(REQ_READ, 16'($urandom), 10'($urandom));
      end
   endtask

   // extremes, unknown request, reads before transform, drop, shrink
   task automatic test_directed();
      begin
         send_req(REQ_READ, '0, 10'd0);
         send_req(REQ_UNKNOWN, 16'h7fff, 10'h3ff);
         send_req(REQ_LOAD, 16'sh7fff, '0);
         send_req(REQ_LOAD, -16'sh8000, '0);
         send_req(REQ_LOAD, 16'sh0001, 10'h3ff);
         send_req(REQ_TRANSFORM, '0, '0);
         send_req(REQ_READ, '0, 10'd0);
         send_req(REQ_READ, '0, 10'd511);
         send_req(REQ_READ, '0, 10'h3ff);
         send_req(REQ_LOAD, -16'sd1, '0);
         send_req(REQ_READ, '0, 10'd1);
         write_len(4'd1);
         send_req(REQ_LOAD, 16'sh7fff, '0);
         send_req(REQ_LOAD, 16'sh7fff, '0);
         send_req(REQ_LOAD, -16'sh8000, '0);
         send_req(REQ_TRANSFORM, '0, '0);
         send_req(REQ_READ, '0, 10'd1);
         send_req(REQ_READ, '0, 10'd2);
         write_len(4'd3);
         repeat (6) load_rand();
         write_len(4'd0);
         send_req(REQ_TRANSFORM, '0, '0);
         read_rand();
         read_rand();
      end
   endtask

   // full-length frame with out-of-range length register
   task automatic test_full_frame();
      begin
         write_len(4'd15);
         repeat (1025) load_rand();
         send_req(REQ_TRANSFORM, '0, '0);
         repeat (8) read_rand();
         write_len(4'd10);
         for (int i = 0; i < 4; i++) send_req(REQ_LOAD, -16'sh8000, '0);
         send_req(REQ_TRANSFORM, '0, '0);
         send_req(REQ_READ, '0, 10'd0);
         send_req(REQ_READ, '0, 10'd1023);
      end
   endtask

   // random frames, small lengths, noise between loads
   task automatic test_random_frames(int target);
      int unsigned lg, n, loads;
      int          stop_at;
      begin
         stop_at = items_sent + target;
         while (items_sent < stop_at) begin
            if (items_sent > stop_at - 150) quiet = 1'b1;
            case ($urandom_range(9))
               0: lg = $urandom_range(1) ? 0 : 9;
               1, 2: lg = $urandom_range(6, 8);
               default: lg = $urandom_range(1, 5);
            endcase
            write_len(4'(lg));
            n = 1 << ((lg < 1) ? 1 : lg);
            loads = $urandom_range(0, n + 2);
            for (int i = 0; i < loads; i++) begin
               if ($urandom_range(9) == 0) begin
                  if ($urandom_range(1)) read_rand();
                  else send_req(REQ_UNKNOWN, 16'($urandom), 10'($urandom));
               end
               load_rand();
            end
            // at random, the sender holds off until everything is back
            if ($urandom_range(3) == 0) wait_drained();
            if ($urandom_range(11) != 0) send_req(REQ_TRANSFORM, 16'($urandom), 10'($urandom));
            repeat ($urandom_range(2, 12)) read_rand();
         end
         quiet = 1'b0;
      end
   endtask

   // stimulus sequence and end of test
   initial begin
      build_twiddles();
      for (int i = 0; i < NMAX; i++) begin
         frame_re[i] = 0;
         frame_im[i] = 0;
      end
      sample_count = 0;
      bins_valid = 1'b0;
      last_frame_lg = 1;
      len_reg = 4'd9;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_frame();
      test_random_frames(820);
      wait_drained();
      repeat (20) @(negedge clock);
      if (pending_bins.size() != 0)
         report_mismatch("leftover expected transactions", pending_bins.size(), 0);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
